// ===== sv/rtdq_pkg.sv =====
// ----------------------------------------------------------------------------
// rtdq_pkg
// Shared sizes, codes and controller/datapath link types for the relay
// toggle delay queue.
// ----------------------------------------------------------------------------
package rtdq_pkg;

	// Queue geometry
	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int AMT_W       = 32;

	// Configuration port
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MODE    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VALUE = CFG_IDX_W'(1);

	// Item actions
	localparam logic ACT_TICK    = 1'b0;
	localparam logic ACT_ENQUEUE = 1'b1;

	// Drive modes
	localparam logic MODE_CONTINUOUS = 1'b0;
	localparam logic MODE_PUSH       = 1'b1;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_HEAD = 4'b0100,
		ST_DONE = 4'b1000
	} ctrl_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;    // latch item, read head entry
		logic exec;      // apply tick or enqueue
		logic head_rd;   // re-read head entry after update
		logic load_out;  // move result into output register
	} ctrl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic out_free;  // output register can take a result this cycle
	} dp_status_t;

endpackage

// ===== sv/rtdq_item_if.sv =====
// ----------------------------------------------------------------------------
// rtdq_item_if
// Input channel: one tick or enqueue transaction.
// ----------------------------------------------------------------------------
interface rtdq_item_if import rtdq_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             action;
	logic [AMT_W-1:0] amount;

	modport source (output valid, output action, output amount, input ready);
	modport sink   (input valid, input action, input amount, output ready);
endinterface

// ===== sv/rtdq_result_if.sv =====
// ----------------------------------------------------------------------------
// rtdq_result_if
// Output channel: relay state after each item.
// ----------------------------------------------------------------------------
interface rtdq_result_if import rtdq_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             relay_value;
	logic             drive_level;
	logic             push_pulse;
	logic [AMT_W-1:0] head_delay;
	logic [CNT_W-1:0] queue_count;
	logic             dropped;

	modport source (output valid, output relay_value, output drive_level,
		output push_pulse, output head_delay, output queue_count,
		output dropped, input ready);
	modport sink   (input valid, input relay_value, input drive_level,
		input push_pulse, input head_delay, input queue_count,
		input dropped, output ready);
endinterface

// ===== sv/rtdq_cfg_if.sv =====
// ----------------------------------------------------------------------------
// rtdq_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rtdq_cfg_if import rtdq_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic                 data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/rtdq_ram.sv =====
// ----------------------------------------------------------------------------
// rtdq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rtdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/rtdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtdq_ctrl
// Sequencer: accept an item, apply it to the queue, re-read the head entry,
// then hand the result to the output register.
// ----------------------------------------------------------------------------
module rtdq_ctrl import rtdq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_EXEC;
			end
			ST_EXEC: state_nxt = ST_HEAD;
			ST_HEAD: state_nxt = ST_DONE;
			ST_DONE: begin
				if (status.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Decode commands
	assign in_ready     = (state_q == ST_IDLE);
	assign cmd.accept   = (state_q == ST_IDLE) && in_valid;
	assign cmd.exec     = (state_q == ST_EXEC);
	assign cmd.head_rd  = (state_q == ST_HEAD);
	assign cmd.load_out = (state_q == ST_DONE) && status.out_free;

endmodule

// ===== sv/rtdq_dp.sv =====
// ----------------------------------------------------------------------------
// rtdq_dp
// Datapath: delay store, queue pointers, relay state, configuration
// registers and the output register.
// ----------------------------------------------------------------------------
module rtdq_dp import rtdq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ctrl_cmd_t        cmd,
	output dp_status_t       status,
	input  logic             item_action,
	input  logic [AMT_W-1:0] item_amount,
	input  logic             cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic             cfg_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             out_relay_value,
	output logic             out_drive_level,
	output logic             out_push_pulse,
	output logic [AMT_W-1:0] out_head_delay,
	output logic [CNT_W-1:0] out_queue_count,
	output logic             out_dropped
);

	logic             drive_mode_q;
	logic             action_q;
	logic [AMT_W-1:0] amount_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic             value_q;
	logic             pin_q;
	logic             pulse_q;
	logic             drop_q;
	logic             out_valid_q;

	logic             ram_we;
	logic [PTR_W-1:0] ram_waddr;
	logic [AMT_W-1:0] ram_wdata;
	logic [AMT_W-1:0] ram_rdata;

	logic             full;
	logic             nonempty;
	logic             do_enq;
	logic             do_reduce;
	logic             do_fire;
	logic [PTR_W-1:0] head_inc;
	logic [PTR_W-1:0] tail_inc;

	// Queue conditions for the item in flight
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign nonempty  = (count_q != '0);
	assign do_enq    = cmd.exec && (action_q == ACT_ENQUEUE) && !full;
	assign do_reduce = cmd.exec && (action_q == ACT_TICK) && nonempty &&
		(ram_rdata > amount_q);
	assign do_fire   = cmd.exec && (action_q == ACT_TICK) && nonempty &&
		!(ram_rdata > amount_q);

	// Wrap pointers at the queue depth
	assign head_inc = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;

	// Store port: write tail on enqueue, write reduced head on partial tick
	assign ram_we    = do_enq || do_reduce;
	assign ram_waddr = do_enq ? tail_q : head_q;
	assign ram_wdata = do_enq ? amount_q : (ram_rdata - amount_q);

	rtdq_ram #(
		.WIDTH (AMT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.accept || cmd.head_rd),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	// Latch the accepted item
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			action_q <= item_action;
			amount_q <= item_amount;
		end
	end

	// Per-item flags
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			pulse_q <= do_fire && (drive_mode_q == MODE_PUSH);
			drop_q  <= (action_q == ACT_ENQUEUE) && full;
		end
	end

	// Queue pointers, relay state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_mode_q <= MODE_CONTINUOUS;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			value_q      <= 1'b0;
			pin_q        <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == CFG_DRIVE_MODE)) begin
				drive_mode_q <= cfg_data;
			end
			if (cfg_we && (cfg_index == CFG_INITIAL_VALUE)) begin
				value_q <= cfg_data;
				pin_q   <= cfg_data;
			end
			if (do_enq) begin
				tail_q  <= tail_inc;
				count_q <= count_q + 1'b1;
			end
			if (do_fire) begin
				head_q  <= head_inc;
				count_q <= count_q - 1'b1;
				value_q <= !value_q;
				pin_q   <= (drive_mode_q == MODE_CONTINUOUS) ? !value_q : 1'b0;
			end
		end
	end

	// Output register handshake
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_relay_value <= value_q;
			out_drive_level <= (drive_mode_q == MODE_CONTINUOUS) ? pin_q : 1'b0;
			out_push_pulse  <= pulse_q;
			out_head_delay  <= nonempty ? ram_rdata : '0;
			out_queue_count <= count_q;
			out_dropped     <= drop_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/relay_toggle_delay_queue_unit.sv =====
// ----------------------------------------------------------------------------
// relay_toggle_delay_queue_unit
// Relay sequencer with a queue of switch delays; one result per item.
// ----------------------------------------------------------------------------
// Each item passes through these steps from acceptance to a loaded result:
// the head entry is read from the delay store, the tick or enqueue is
// applied with at most one write, the new head entry is read back, and the
// result is registered once the output register can take it, which stalls
// while the previous result is still held. The single read and single write
// port of the delay store keep these steps apart. A new item is accepted as
// soon as the sequencer is idle, even while the last result still waits in
// the output register. Configuration writes are always taken and are meant for idle periods only.
module relay_toggle_delay_queue_unit import rtdq_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	rtdq_item_if.sink     item,
	rtdq_result_if.source result,
	rtdq_cfg_if.sink      cfg
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Configuration always ready
	assign cfg.ready = 1'b1;

	rtdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.status   (status),
		.cmd      (cmd)
	);

	rtdq_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.item_action     (item.action),
		.item_amount     (item.amount),
		.cfg_we          (cfg.valid),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.out_valid       (result.valid),
		.out_ready       (result.ready),
		.out_relay_value (result.relay_value),
		.out_drive_level (result.drive_level),
		.out_push_pulse  (result.push_pulse),
		.out_head_delay  (result.head_delay),
		.out_queue_count (result.queue_count),
		.out_dropped     (result.dropped)
	);

endmodule
